// ----- rtl/elias_delta_bit_packer_unit_defines.svh -----
// Assertion macros for the Elias delta packer.
// Each expects clk and rst_n in the scope where it is used.
`ifndef ELIAS_DELTA_BIT_PACKER_UNIT_DEFINES_SVH
`define ELIAS_DELTA_BIT_PACKER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ELDP_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("eldp: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define ELDP_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("eldp: next-cycle check failed");

`endif

// ----- rtl/eldp_pkg.sv -----
`timescale 1ns / 1ps

package eldp_pkg;

  // width of the value field on the port, and how many of its bits are coded
  localparam int VALUE_W     = 32;
  localparam int VALUE_WIDTH = 32;

  localparam int LEN_W  = $clog2(VALUE_WIDTH + 1);          // bit length n
  localparam int U_W    = $clog2(LEN_W);                    // index of top set bit of n
  localparam int CODE_W = 2 * (LEN_W - 1) + VALUE_WIDTH;    // longest code
  localparam int CLEN_W = $clog2(CODE_W + 1);

  localparam int WORD_W  = 64;
  localparam int PCNT_W  = 6;
  localparam int BYTES_W = 4;
  localparam int TOTAL_W = 32;

  localparam logic [BYTES_W-1:0] FULL_BYTES = BYTES_W'(WORD_W / 8);

  localparam int MAX_RES = 2;
  localparam int PUSH_W  = $clog2(MAX_RES + 1);

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [CLEN_W-1:0] len;
    logic              zero;
    logic              last;
  } code_t;

  typedef struct packed {
    logic [WORD_W-1:0]  word;
    logic [BYTES_W-1:0] word_bytes;
    logic               end_of_stream;
    logic [TOTAL_W-1:0] total_bytes;
    logic               zero_seen;
  } result_t;

endpackage

// ----- rtl/eldp_in_if.sv -----
`timescale 1ns / 1ps

interface eldp_in_if;
  logic                        valid;
  logic                        ready;
  logic [eldp_pkg::VALUE_W-1:0] value;
  logic                        last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

// ----- rtl/eldp_out_if.sv -----
`timescale 1ns / 1ps

interface eldp_out_if;
  logic                          valid;
  logic                          ready;
  logic [eldp_pkg::WORD_W-1:0]   word;
  logic [eldp_pkg::BYTES_W-1:0]  word_bytes;
  logic                          end_of_stream;
  logic [eldp_pkg::TOTAL_W-1:0]  total_bytes;
  logic                          zero_seen;

  modport source (output valid, output word, output word_bytes, output end_of_stream,
                  output total_bytes, output zero_seen, input ready);
  modport sink   (input valid, input word, input word_bytes, input end_of_stream,
                  input total_bytes, input zero_seen, output ready);
  modport mon    (input valid, input word, input word_bytes, input end_of_stream,
                  input total_bytes, input zero_seen, input ready);
endinterface

// ----- rtl/elias_delta_bit_packer_unit.sv -----
`timescale 1ns / 1ps

// Elias delta bit packer.
// in_ch (valid/ready): one positive integer per beat plus a last flag.
// out_ch (valid/ready): packed 64-bit words, stream byte 0 in bits 7..0.
// Full words leave as they fill; the beat marked last flushes the partial
// word with end_of_stream set, the total byte count (saturating) and the
// sticky flag for zero values, which are skipped.
// A beat taken on in_ch is held in the input register, then coded and
// merged into the pending word once the queue has room; its results are
// written to the output queue and offered on out_ch from there.
// Throughput: one input beat per cycle while the queue has room and each
// beat yields at most one result; a beat yielding two results takes two
// output beats. The output side is a four-entry queue, and the input
// register moves on only while the queue has two free entries, so
// in_ch.ready never depends on out_ch.ready in the same cycle.
// Reset (rst_n low at a clock edge) empties the input register and queue
// and clears the pending bits, counters and error flag. When the receiver
// stalls, the queue fills and in_ch.ready falls; nothing is dropped.
module elias_delta_bit_packer_unit (
  input  logic       clk,
  input  logic       rst_n,
  eldp_in_if.sink    in_ch,
  eldp_out_if.source out_ch
);

  logic                         in_valid_r;
  logic [eldp_pkg::VALUE_W-1:0] in_value_r;
  logic                         in_last_r;
  logic                         room;
  logic                         consume;
  eldp_pkg::code_t              code;
  logic [eldp_pkg::PUSH_W-1:0]  push_cnt;
  eldp_pkg::result_t            res0, res1;

  assign consume     = in_valid_r && room;
  assign in_ch.ready = !in_valid_r || room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_value_r <= in_ch.value;
      in_last_r  <= in_ch.last;
    end
  end

  eldp_code_gen u_code_gen (
    .value  (in_value_r),
    .last   (in_last_r),
    .code_o (code)
  );

  eldp_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (consume),
    .item       (code),
    .push_cnt   (push_cnt),
    .res0       (res0),
    .res1       (res1)
  );

  eldp_out_fifo u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (push_cnt),
    .din0     (res0),
    .din1     (res1),
    .room     (room),
    .out_ch   (out_ch)
  );

endmodule

// ----- rtl/eldp_code_gen.sv -----
`timescale 1ns / 1ps

module eldp_code_gen (
  input  logic [eldp_pkg::VALUE_W-1:0] value,
  input  logic                         last,
  output eldp_pkg::code_t              code_o
);

  function automatic logic [eldp_pkg::LEN_W-1:0] bit_length(
    input logic [eldp_pkg::VALUE_WIDTH-1:0] v
  );
    logic [eldp_pkg::LEN_W-1:0] n;
    n = '0;
    for (int i = 0; i < eldp_pkg::VALUE_WIDTH; i++) begin
      if (v[i]) n = eldp_pkg::LEN_W'(i + 1);
    end
    return n;
  endfunction

  function automatic logic [eldp_pkg::U_W-1:0] top_bit_pos(
    input logic [eldp_pkg::LEN_W-1:0] n
  );
    logic [eldp_pkg::U_W-1:0] u;
    u = '0;
    for (int i = 0; i < eldp_pkg::LEN_W; i++) begin
      if (n[i]) u = eldp_pkg::U_W'(i);
    end
    return u;
  endfunction

  logic [eldp_pkg::VALUE_WIDTH-1:0] v;
  logic [eldp_pkg::LEN_W-1:0]       n;
  logic [eldp_pkg::U_W-1:0]         u;
  logic [eldp_pkg::LEN_W-1:0]       n_trim;
  logic [eldp_pkg::CODE_W-1:0]      head;
  logic [eldp_pkg::VALUE_WIDTH-1:0] low_mask;
  logic [eldp_pkg::VALUE_WIDTH-1:0] low_bits;

  always_comb begin
    v        = value[eldp_pkg::VALUE_WIDTH-1:0];
    n        = bit_length(v);
    u        = top_bit_pos(n);
    // length with its top bit dropped, then a marker 1 underneath
    n_trim   = n & ~(eldp_pkg::LEN_W'(1) << u);
    head     = (eldp_pkg::CODE_W'(n_trim) << 1) | eldp_pkg::CODE_W'(1);
    low_mask = ~({eldp_pkg::VALUE_WIDTH{1'b1}} << (n - eldp_pkg::LEN_W'(1)));
    low_bits = v & low_mask;

    code_o.code = (head << u) | (eldp_pkg::CODE_W'(low_bits) << {u, 1'b1});
    code_o.len  = eldp_pkg::CLEN_W'({u, 1'b0}) + eldp_pkg::CLEN_W'(n);
    code_o.zero = (n == '0);
    code_o.last = last;
  end

endmodule

// ----- rtl/eldp_merge.sv -----
`timescale 1ns / 1ps

module eldp_merge (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         item_valid,
  input  eldp_pkg::code_t              item,
  output logic [eldp_pkg::PUSH_W-1:0]  push_cnt,
  output eldp_pkg::result_t            res0,
  output eldp_pkg::result_t            res1
);

  localparam int SUM_W = eldp_pkg::PCNT_W + 1;
  localparam int TS_W  = eldp_pkg::TOTAL_W + 1;

  logic [eldp_pkg::WORD_W-1:0]  pend_bits_r, pend_bits_nxt;
  logic [eldp_pkg::PCNT_W-1:0]  pend_cnt_r,  pend_cnt_nxt;
  logic [eldp_pkg::TOTAL_W-1:0] byte_tot_r,  byte_tot_nxt;
  logic                         err_r,       err_nxt;

  logic [eldp_pkg::WORD_W-1:0]  code_w, merged, rest, bits_a;
  logic [SUM_W-1:0]             sum, pb_s;
  logic                         full;
  logic [eldp_pkg::PCNT_W-1:0]  cnt_a;
  logic [TS_W-1:0]              bt8_s, tot_s;
  logic [eldp_pkg::TOTAL_W-1:0] bt8, bt_a, total;
  logic [eldp_pkg::BYTES_W-1:0] pb;
  eldp_pkg::result_t            full_res, flush_res;

  always_comb begin
    code_w  = eldp_pkg::WORD_W'(item.code);
    merged  = pend_bits_r | (code_w << pend_cnt_r);
    sum     = SUM_W'(pend_cnt_r) + SUM_W'(item.len);
    full    = !item.zero && sum[eldp_pkg::PCNT_W];
    // overflow part of the code that did not fit in the emitted word
    rest    = code_w >> (SUM_W'(eldp_pkg::WORD_W) - SUM_W'(pend_cnt_r));
    err_nxt = err_r | item.zero;

    bt8_s = TS_W'(byte_tot_r) + TS_W'(eldp_pkg::FULL_BYTES);
    bt8   = bt8_s[eldp_pkg::TOTAL_W] ? '1 : bt8_s[eldp_pkg::TOTAL_W-1:0];

    if (item.zero) begin
      bits_a = pend_bits_r;
      cnt_a  = pend_cnt_r;
      bt_a   = byte_tot_r;
    end else if (full) begin
      bits_a = rest;
      cnt_a  = sum[eldp_pkg::PCNT_W-1:0];
      bt_a   = bt8;
    end else begin
      bits_a = merged;
      cnt_a  = sum[eldp_pkg::PCNT_W-1:0];
      bt_a   = byte_tot_r;
    end

    pb_s  = (SUM_W'(cnt_a) + SUM_W'(7)) >> 3;
    pb    = pb_s[eldp_pkg::BYTES_W-1:0];
    tot_s = TS_W'(bt_a) + TS_W'(pb);
    total = tot_s[eldp_pkg::TOTAL_W] ? '1 : tot_s[eldp_pkg::TOTAL_W-1:0];

    full_res.word          = merged;
    full_res.word_bytes    = eldp_pkg::FULL_BYTES;
    full_res.end_of_stream = 1'b0;
    full_res.total_bytes   = '0;
    full_res.zero_seen     = err_nxt;

    // with nothing pending bits_a is already zero, so this covers the empty flush
    flush_res.word          = bits_a;
    flush_res.word_bytes    = pb;
    flush_res.end_of_stream = 1'b1;
    flush_res.total_bytes   = total;
    flush_res.zero_seen     = err_nxt;

    res0     = flush_res;
    res1     = flush_res;
    push_cnt = '0;
    if (!item.last) begin
      res0     = full_res;
      push_cnt = full ? eldp_pkg::PUSH_W'(1) : '0;
    end else if (cnt_a != '0) begin
      if (full) begin
        res0     = full_res;
        push_cnt = eldp_pkg::PUSH_W'(2);
      end else begin
        push_cnt = eldp_pkg::PUSH_W'(1);
      end
    end else if (full) begin
      // exact fill: the full word itself closes the stream
      res0               = full_res;
      res0.end_of_stream = 1'b1;
      res0.total_bytes   = total;
      push_cnt           = eldp_pkg::PUSH_W'(1);
    end else begin
      push_cnt = eldp_pkg::PUSH_W'(1);
    end

    if (item.last) begin
      pend_bits_nxt = '0;
      pend_cnt_nxt  = '0;
      byte_tot_nxt  = '0;
      err_nxt       = 1'b0;
    end else begin
      pend_bits_nxt = bits_a;
      pend_cnt_nxt  = cnt_a;
      byte_tot_nxt  = bt_a;
    end

    if (!item_valid) push_cnt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
      byte_tot_r  <= '0;
      err_r       <= 1'b0;
    end else if (item_valid) begin
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      byte_tot_r  <= byte_tot_nxt;
      err_r       <= err_nxt;
    end
  end

endmodule

// ----- rtl/eldp_out_fifo.sv -----
`timescale 1ns / 1ps

module eldp_out_fifo (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [eldp_pkg::PUSH_W-1:0]  push_cnt,
  input  eldp_pkg::result_t            din0,
  input  eldp_pkg::result_t            din1,
  output logic                         room,
  eldp_out_if.source                   out_ch
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  eldp_pkg::result_t mem_r [DEPTH];
  logic [AW-1:0]     wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              pop;
  eldp_pkg::result_t head;

  // two free slots needed, judged on occupancy alone so no ready-to-ready path
  assign room = (count_r <= CW'(DEPTH - eldp_pkg::MAX_RES));
  assign pop  = out_ch.valid && out_ch.ready;
  assign head = mem_r[rp_r];

  assign out_ch.valid         = (count_r != '0);
  assign out_ch.word          = head.word;
  assign out_ch.word_bytes    = head.word_bytes;
  assign out_ch.end_of_stream = head.end_of_stream;
  assign out_ch.total_bytes   = head.total_bytes;
  assign out_ch.zero_seen     = head.zero_seen;

  always_comb begin
    wp_nxt    = wp_r + AW'(push_cnt);
    rp_nxt    = rp_r + AW'(pop);
    count_nxt = count_r + CW'(push_cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_cnt != '0) mem_r[wp_r] <= din0;
    if (push_cnt == eldp_pkg::PUSH_W'(2)) mem_r[wp_r + AW'(1)] <= din1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ----- rtl/eldp_checker.sv -----
`timescale 1ns / 1ps
`include "elias_delta_bit_packer_unit_defines.svh"

module eldp_checker (
  input logic        clk,
  input logic        rst_n,
  eldp_out_if.source out_ch
);

  `ELDP_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready,
                    out_ch.valid && $stable(out_ch.word) && $stable(out_ch.word_bytes))
  `ELDP_ASSERT_SAME(a_bytes_range, out_ch.valid, out_ch.word_bytes <= eldp_pkg::FULL_BYTES)
  `ELDP_ASSERT_SAME(a_mid_word_full, out_ch.valid && !out_ch.end_of_stream,
                    out_ch.word_bytes == eldp_pkg::FULL_BYTES && out_ch.total_bytes == '0)
  `ELDP_ASSERT_SAME(a_empty_flush, out_ch.valid && out_ch.word_bytes == '0,
                    out_ch.word == '0 && out_ch.end_of_stream)

endmodule

bind elias_delta_bit_packer_unit eldp_checker u_eldp_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .out_ch (out_ch)
);

// ----- dv/tb_elias_delta_bit_packer_unit.sv -----
`timescale 1ns / 1ps

module tb_elias_delta_bit_packer_unit;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 10;

  logic clk;
  logic rst_n;

  eldp_in_if  in_ch ();
  eldp_out_if out_ch ();

  elias_delta_bit_packer_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // packer state as the block should hold it
  logic [eldp_pkg::WORD_W-1:0]  pend_bits;
  int unsigned                  pend_count;
  logic [eldp_pkg::TOTAL_W-1:0] word_total;
  logic                         zero_flag;

  eldp_pkg::result_t expected_words[$];

  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold_cycles;
  int fail_count;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned bit_len(input logic [eldp_pkg::WORD_W-1:0] x);
    for (int i = eldp_pkg::WORD_W - 1; i >= 0; i--) begin
      if (x[i]) return i + 1;
    end
    return 0;
  endfunction

  function automatic logic [eldp_pkg::TOTAL_W-1:0] sat_add(
    input logic [eldp_pkg::TOTAL_W-1:0] a,
    input logic [eldp_pkg::TOTAL_W-1:0] b
  );
    logic [eldp_pkg::TOTAL_W:0] s;
    s = a + b;
    return s[eldp_pkg::TOTAL_W] ? '1 : s[eldp_pkg::TOTAL_W-1:0];
  endfunction

  function automatic void clear_packer();
    pend_bits  = '0;
    pend_count = 0;
    word_total = '0;
    zero_flag  = 1'b0;
  endfunction

  // Appends the delta code of one accepted beat and queues the words it yields.
  function automatic void pack_value(input logic [eldp_pkg::VALUE_W-1:0] raw,
                                     input logic lst);
    logic [eldp_pkg::WORD_W-1:0]  v;
    logic [eldp_pkg::WORD_W-1:0]  zig;
    logic [eldp_pkg::WORD_W-1:0]  low;
    logic [eldp_pkg::WORD_W-1:0]  code;
    logic [eldp_pkg::WORD_W-1:0]  merged;
    logic [eldp_pkg::TOTAL_W-1:0] total;
    int unsigned                  n;
    int unsigned                  u;
    int unsigned                  len;
    int unsigned                  sum;
    int unsigned                  pb;
    int unsigned                  nres;
    eldp_pkg::result_t            r;
    v    = eldp_pkg::WORD_W'(raw[eldp_pkg::VALUE_WIDTH-1:0]);
    nres = 0;
    if (v == '0) begin
      zero_flag = 1'b1;
    end else begin
      n    = bit_len(v);
      u    = bit_len(eldp_pkg::WORD_W'(n)) - 1;
      zig  = ((eldp_pkg::WORD_W'(n) & ~(64'd1 << u)) << 1) | 64'd1;
      low  = v & ((64'd1 << (n - 1)) - 64'd1);
      code = (zig << u) | (low << (2 * u + 1));
      len  = 2 * u + n;
      merged = pend_bits | (code << pend_count);
      sum    = pend_count + len;
      if (sum >= eldp_pkg::WORD_W) begin
        word_total = sat_add(word_total, 8);
        r = '{word: merged, word_bytes: eldp_pkg::FULL_BYTES, end_of_stream: 1'b0,
              total_bytes: '0, zero_seen: zero_flag};
        expected_words.push_back(r);
        nres++;
        // pend_count is non-zero here as no code exceeds 42 bits
        pend_bits  = code >> (eldp_pkg::WORD_W - pend_count);
        pend_count = sum - eldp_pkg::WORD_W;
      end else begin
        pend_bits  = merged;
        pend_count = sum;
      end
    end
    if (lst) begin
      pb    = (pend_count + 7) >> 3;
      total = sat_add(word_total, pb);
      if (pend_count > 0) begin
        r = '{word: pend_bits, word_bytes: eldp_pkg::BYTES_W'(pb), end_of_stream: 1'b1,
              total_bytes: total, zero_seen: zero_flag};
        expected_words.push_back(r);
      end else if (nres > 0) begin
        // exact fill: the full word closes the stream
        r = expected_words.pop_back();
        r.end_of_stream = 1'b1;
        r.total_bytes   = total;
        expected_words.push_back(r);
      end else begin
        r = '{word: '0, word_bytes: '0, end_of_stream: 1'b1,
              total_bytes: total, zero_seen: zero_flag};
        expected_words.push_back(r);
      end
      clear_packer();
    end
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  function automatic void check_word();
    eldp_pkg::result_t got;
    eldp_pkg::result_t want;
    got = '{word: out_ch.word, word_bytes: out_ch.word_bytes,
            end_of_stream: out_ch.end_of_stream, total_bytes: out_ch.total_bytes,
            zero_seen: out_ch.zero_seen};
    if (expected_words.size() == 0) begin
      note_failure($sformatf("unexpected word %h bytes %0d eos %0b total %0d zero %0b",
                             got.word, got.word_bytes, got.end_of_stream,
                             got.total_bytes, got.zero_seen));
      return;
    end
    want = expected_words.pop_front();
    if (got.word !== want.word || got.word_bytes !== want.word_bytes ||
        got.end_of_stream !== want.end_of_stream ||
        got.total_bytes !== want.total_bytes || got.zero_seen !== want.zero_seen) begin
      note_failure($sformatf(
        "exp word %h bytes %0d eos %0b total %0d zero %0b / got %h %0d %0b %0d %0b",
        want.word, want.word_bytes, want.end_of_stream, want.total_bytes, want.zero_seen,
        got.word, got.word_bytes, got.end_of_stream, got.total_bytes, got.zero_seen));
    end
  endfunction

  // result side: check each beat, then decide ready for the next cycle
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) check_word();
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_value(input logic [eldp_pkg::VALUE_W-1:0] v, input logic lst);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.last  <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pack_value(v, lst);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [eldp_pkg::VALUE_W-1:0] random_value();
    int unsigned                  nb;
    logic [eldp_pkg::VALUE_W-1:0] v;
    if ($urandom_range(99) < 4) return '0;
    nb = $urandom_range(eldp_pkg::VALUE_W, 1);
    v  = $urandom;
    if (nb < eldp_pkg::VALUE_W) v &= (32'd1 << nb) - 32'd1;
    v[nb-1] = 1'b1;
    return v;
  endfunction

  // Random streams of mostly short sequences; zeros are the noise.
  task automatic test_random_stream(input int count, input int tx_pct, input int rx_pct);
    int sent;
    logic [eldp_pkg::VALUE_W-1:0] v;
    logic lst;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < count) begin
      v   = random_value();
      lst = ($urandom_range(15) == 0) || (sent == count - 1);
      send_value(v, lst);
      if (v != '0 || lst) sent++;
    end
    drain_results();
  endtask

  task automatic test_flush_cases();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_value(32'd0, 1'b1);           // empty flush with the zero flag
    send_value(32'd1, 1'b1);           // one-bit code
    send_value(32'd0, 1'b0);
    send_value(32'd2, 1'b1);
    drain_results();
  endtask

  task automatic test_extreme_values();
    send_value(32'hFFFF_FFFF, 1'b1);
    send_value(32'h8000_0000, 1'b0);
    send_value(32'd3, 1'b0);
    send_value(32'h7FFF_FFFF, 1'b1);
    drain_results();
  endtask

  task automatic test_word_boundaries();
    // 42 + 21 + 1 bits: the last beat fills the word exactly
    send_value(32'hFFFF_FFFF, 1'b0);
    send_value(32'h0000_7FFF, 1'b0);
    send_value(32'd1, 1'b1);
    // full word and a partial flush from one beat
    send_value(32'hFFFF_FFFF, 1'b0);
    send_value(32'hFFFF_FFFF, 1'b1);
    // exact fill without last, then a zero closes the stream
    send_value(32'hFFFF_FFFF, 1'b0);
    send_value(32'h0000_7FFF, 1'b0);
    send_value(32'd1, 1'b0);
    send_value(32'd0, 1'b1);
    drain_results();
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_cycles = 300;
    for (int i = 0; i < 60; i++) send_value(random_value(), (i % 20) == 19);
    drain_results();
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.value    <= '0;
    in_ch.last     <= 1'b0;
    tx_idle_pct    = 0;
    rx_idle_pct    = 0;
    rx_hold_cycles = 0;
    fail_count     = 0;
    cycle_count    = 0;
    clear_packer();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_flush_cases();
    test_extreme_values();
    test_word_boundaries();
    test_backpressure();
    test_random_stream(500, 21, 62);
    test_random_stream(500, 62, 21);
    test_random_stream(500, 0, 0);

    if (expected_words.size() != 0) note_failure("words still outstanding");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/eldp_pkg.sv
rtl/eldp_in_if.sv
rtl/eldp_out_if.sv
rtl/eldp_code_gen.sv
rtl/eldp_merge.sv
rtl/eldp_out_fifo.sv
rtl/elias_delta_bit_packer_unit.sv
rtl/eldp_checker.sv
dv/tb_elias_delta_bit_packer_unit.sv
